>>> rtl/fxalu_pkg.sv
// Shared operation codes for the signed fixed-point ALU.
// No dependencies; imported by the top level and the testbench.
`default_nettype none
package fxalu_pkg;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_MIN = 3'd4,
        MODE_MAX = 3'd5,
        MODE_INC = 3'd6,
        MODE_DEC = 3'd7
    } mode_t;

endpackage
`default_nettype wire

>>> rtl/fxalu_div_step.sv
// One restoring-division step: shift in a dividend bit, trial subtract.
// No dependencies; instantiated once per divider stage by the top level.
`default_nettype none
module fxalu_div_step #(
    parameter int WORD_BITS = 32,
    parameter int QUO_BITS  = 40
) (
    input  logic [WORD_BITS-1:0] rem_in,
    input  logic [WORD_BITS-1:0] div_in,
    input  logic [QUO_BITS-1:0]  nq_in,
    output logic [WORD_BITS-1:0] rem_out,
    output logic [QUO_BITS-1:0]  nq_out
);

    logic [WORD_BITS:0] trial;
    logic [WORD_BITS:0] diff;
    logic               ge;

    always_comb begin
        trial   = {rem_in, nq_in[QUO_BITS-1]};
        diff    = trial - {1'b0, div_in};
        ge      = (trial >= {1'b0, div_in});
        rem_out = ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
        nq_out  = {nq_in[QUO_BITS-2:0], ge};
    end

endmodule
`default_nettype wire

>>> rtl/fixed_point_q24_8_alu.sv
// Signed fixed-point ALU, Q(WORD_BITS-FRAC_BITS).FRAC_BITS, fully pipelined.
// The pipeline depth is set by the divider, which resolves one quotient bit per
// stage; every mode takes the same path through the pipeline.
// Throughput: one transfer per cycle; a stalled output holds the whole pipe.
// Reset: synchronous active-low aresetn clears all valid bits.
// Depends on fxalu_pkg and fxalu_div_step.
`default_nettype none
module fixed_point_q24_8_alu #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  fxalu_pkg::mode_t              s_mode,
    input  logic signed [WORD_BITS-1:0]   s_operand_a,
    input  logic signed [WORD_BITS-1:0]   s_operand_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [WORD_BITS-1:0]   m_result_raw,
    output logic                          m_a_less,
    output logic                          m_a_equal,
    output logic                          m_a_greater,
    output logic                          m_overflow,
    output logic                          m_divide_by_zero
);
    import fxalu_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int Q  = WORD_BITS + FRAC_BITS;
    localparam int PW = 2 * WORD_BITS + 1;
    localparam logic [W-1:0]  MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MIN_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [PW-1:0] RND     = (PW'(1) << FRAC_BITS) >> 1;

    typedef struct packed {
        logic            vld;
        mode_t           mode;
        logic            neg;
        logic            a_neg;
        logic            lt;
        logic            eq;
        logic            gt;
        logic            dz;
        logic            ovf;
        logic [W-1:0]    res;
        logic [W-1:0]    ma;
        logic [W-1:0]    d;
        logic [W-1:0]    r;
        logic [Q-1:0]    nq;
        logic [2*W-1:0]  prod;
    } stg_t;

    function automatic logic [W:0] sat_sign(input logic [PW-1:0] m, input logic neg);
        logic [PW-1:0] lim;
        logic [W-1:0]  low;
        begin
            lim = neg ? PW'(MIN_NEG) : PW'(MAX_POS);
            low = m[W-1:0];
            if (m > lim) begin
                sat_sign = {neg ? MIN_NEG : MAX_POS, 1'b1};
            end else begin
                sat_sign = {neg ? (W'(0) - low) : low, 1'b0};
            end
        end
    endfunction

    logic                 en;
    logic                 in_vld_reg;
    mode_t                in_mode_reg;
    logic signed [W-1:0]  in_a_reg;
    logic signed [W-1:0]  in_b_reg;

    stg_t pipe_reg  [0:Q];
    stg_t pipe_next [0:Q];

    logic                 m_valid_reg;
    logic [W-1:0]         res_reg, res_next;
    logic                 lt_reg, eq_reg, gt_reg, ovf_reg, ovf_next, dz_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_valid;
        end
        if (en) begin
            in_mode_reg <= s_mode;
            in_a_reg    <= s_operand_a;
            in_b_reg    <= s_operand_b;
        end
    end

    always_comb begin
        pipe_next[0]       = '0;
        pipe_next[0].vld   = in_vld_reg;
        pipe_next[0].mode  = in_mode_reg;
        pipe_next[0].neg   = in_a_reg[W-1] ^ in_b_reg[W-1];
        pipe_next[0].a_neg = in_a_reg[W-1];
        pipe_next[0].lt    = in_a_reg < in_b_reg;
        pipe_next[0].eq    = in_a_reg == in_b_reg;
        pipe_next[0].gt    = in_a_reg > in_b_reg;
        pipe_next[0].dz    = (in_mode_reg == MODE_DIV) && (in_b_reg == '0);
        pipe_next[0].ma    = in_a_reg[W-1] ? W'(0) - in_a_reg : in_a_reg;
        pipe_next[0].d     = in_b_reg[W-1] ? W'(0) - in_b_reg : in_b_reg;
        pipe_next[0].nq    = Q'(pipe_next[0].ma) << FRAC_BITS;
        case (in_mode_reg)
            MODE_ADD: pipe_next[0].res = in_a_reg + in_b_reg;
            MODE_SUB: pipe_next[0].res = in_a_reg - in_b_reg;
            MODE_MIN: pipe_next[0].res = (in_a_reg > in_b_reg) ? in_b_reg : in_a_reg;
            MODE_MAX: pipe_next[0].res = (in_a_reg < in_b_reg) ? in_b_reg : in_a_reg;
            MODE_INC: pipe_next[0].res = in_a_reg + W'(1);
            MODE_DEC: pipe_next[0].res = in_a_reg - W'(1);
            default:  pipe_next[0].res = '0;
        endcase
    end

    genvar k;
    generate
        for (k = 1; k <= Q; k++) begin : g_stage
            logic [W-1:0]  rem_step;
            logic [Q-1:0]  nq_step;
            logic [PW-1:0] rounded;
            logic [W:0]    fin;

            fxalu_div_step #(
                .WORD_BITS (W),
                .QUO_BITS  (Q)
            ) u_step (
                .rem_in  (pipe_reg[k-1].r),
                .div_in  (pipe_reg[k-1].d),
                .nq_in   (pipe_reg[k-1].nq),
                .rem_out (rem_step),
                .nq_out  (nq_step)
            );

            always_comb begin
                rounded      = (PW'(pipe_reg[k-1].prod) + RND) >> FRAC_BITS;
                fin          = sat_sign(rounded, pipe_reg[k-1].neg);
                pipe_next[k]    = pipe_reg[k-1];
                pipe_next[k].r  = rem_step;
                pipe_next[k].nq = nq_step;
                if (k == 2) begin
                    pipe_next[k].prod = pipe_reg[k-1].ma * pipe_reg[k-1].d;
                end
                if (k == 3 && pipe_reg[k-1].mode == MODE_MUL) begin
                    pipe_next[k].res = fin[W:1];
                    pipe_next[k].ovf = fin[0];
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        for (int i = 0; i <= Q; i++) begin
            if (!aresetn) begin
                pipe_reg[i].vld <= 1'b0;
            end else if (en) begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    logic [PW-1:0] quo;
    logic [W:0]    div_fin;
    logic          rnd_up;

    always_comb begin
        rnd_up   = pipe_reg[Q].r >= (pipe_reg[Q].d - pipe_reg[Q].r);
        quo      = PW'(pipe_reg[Q].nq) + PW'(rnd_up);
        div_fin  = sat_sign(quo, pipe_reg[Q].neg);
        res_next = pipe_reg[Q].res;
        ovf_next = pipe_reg[Q].ovf;
        if (pipe_reg[Q].mode == MODE_DIV) begin
            if (pipe_reg[Q].dz) begin
                res_next = pipe_reg[Q].a_neg ? MIN_NEG : MAX_POS;
                ovf_next = 1'b1;
            end else begin
                res_next = div_fin[W:1];
                ovf_next = div_fin[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= pipe_reg[Q].vld;
        end
        if (en) begin
            res_reg <= res_next;
            lt_reg  <= pipe_reg[Q].lt;
            eq_reg  <= pipe_reg[Q].eq;
            gt_reg  <= pipe_reg[Q].gt;
            ovf_reg <= ovf_next;
            dz_reg  <= pipe_reg[Q].dz;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_raw     = res_reg;
    assign m_a_less         = lt_reg;
    assign m_a_equal        = eq_reg;
    assign m_a_greater      = gt_reg;
    assign m_overflow       = ovf_reg;
    assign m_divide_by_zero = dz_reg;

`ifndef ASSERT_OFF
    a_dz_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_overflow)
        else $error("divide by zero without overflow");

    a_cmp_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot({m_a_less, m_a_equal, m_a_greater}))
        else $error("compare flags not exclusive");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> (m_result_raw == MAX_POS) || (m_result_raw == MIN_NEG))
        else $error("overflow without saturated result");
`endif

endmodule
`default_nettype wire

>>> tb/fixed_point_q24_8_alu_tb.sv
// Testbench for the Q24.8 fixed-point ALU: a directed table and then random
// transfers, each result checked against an integer predictor of the ALU.
// Depends on fxalu_pkg and fixed_point_q24_8_alu.
`timescale 1ns / 1ps
module fixed_point_q24_8_alu_tb;
    import fxalu_pkg::*;

    localparam int FRAC = 8;
    localparam int LATENCY = 42;
    localparam longint MAX_CYCLES = 400000;
    localparam logic signed [31:0] WMAX = 32'sh7fffffff;
    localparam logic signed [31:0] WMIN = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] raw;
        logic lt;
        logic eq;
        logic gt;
        logic ovf;
        logic dz;
    } alu_res_t;

    typedef struct {
        mode_t mode;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic known;
        alu_res_t res;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    mode_t s_mode = MODE_ADD;
    logic signed [31:0] s_operand_a = '0;
    logic signed [31:0] s_operand_b = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_result_raw;
    logic m_a_less, m_a_equal, m_a_greater, m_overflow, m_divide_by_zero;

    alu_res_t pending[$];
    int errors = 0;
    int table_errors = 0;
    longint cycles = 0;
    int send_idle = 0;
    int recv_stall = 0;

    fixed_point_q24_8_alu i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_raw(m_result_raw),
        .m_a_less(m_a_less), .m_a_equal(m_a_equal), .m_a_greater(m_a_greater),
        .m_overflow(m_overflow), .m_divide_by_zero(m_divide_by_zero)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply the sign to a rounded magnitude and saturate.
    function automatic logic signed [31:0] sat_signed(logic [127:0] m, logic neg,
                                                      output logic ovf);
        ovf = 1'b0;
        if (neg) begin
            if (m > 128'h80000000) begin
                ovf = 1'b1;
                return WMIN;
            end
            return -$signed(m[31:0]);
        end
        if (m > 128'h7fffffff) begin
            ovf = 1'b1;
            return WMAX;
        end
        return m[31:0];
    endfunction

    function automatic alu_res_t alu_predict(mode_t mode, logic signed [31:0] a,
                                             logic signed [31:0] b);
        alu_res_t r;
        logic [127:0] ma, mb, q, rem;
        logic neg, ovf;
        r = '0;
        r.lt = a < b;
        r.eq = a == b;
        r.gt = a > b;
        ma = a[31] ? 128'(-64'(a)) : 128'(a);
        mb = b[31] ? 128'(-64'(b)) : 128'(b);
        neg = a[31] ^ b[31];
        case (mode)
            MODE_ADD: r.raw = a + b;
            MODE_SUB: r.raw = a - b;
            MODE_MUL: begin
                q = (ma * mb + (128'd1 << (FRAC - 1))) >> FRAC;
                r.raw = sat_signed(q, neg, ovf);
                r.ovf = ovf;
            end
            MODE_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                    r.ovf = 1'b1;
                    r.raw = a[31] ? WMIN : WMAX;
                end else begin
                    q = (ma << FRAC) / mb;
                    rem = (ma << FRAC) % mb;
                    if (rem >= mb - rem) q = q + 1;
                    r.raw = sat_signed(q, neg, ovf);
                    r.ovf = ovf;
                end
            end
            MODE_MIN: r.raw = r.gt ? b : a;
            MODE_MAX: r.raw = r.lt ? b : a;
            MODE_INC: r.raw = a + 1;
            default: r.raw = a - 1;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return WMAX - $urandom_range(0, 3);
            1: return WMIN + $urandom_range(0, 3);
            2: return $signed($urandom_range(0, 8)) - 4;
            3, 4: return $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
            5: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (aresetn) m_ready <= ($urandom_range(0, 99) >= recv_stall);
        if (aresetn && m_valid && m_ready) begin
            alu_res_t got, want;
            got = '{m_result_raw, m_a_less, m_a_equal, m_a_greater, m_overflow,
                    m_divide_by_zero};
            if (pending.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10) $display("unexpected transfer %p", got);
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    errors <= errors + 1;
                    if (errors < 10) $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    task automatic send_item(mode_t mode, logic signed [31:0] a, logic signed [31:0] b);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_operand_a <= a;
        s_operand_b <= b;
        pending.push_back(alu_predict(mode, a, b));
        do @(posedge aclk); while (!s_ready);
    endtask

    row_t dir_rows[$];
    row_t row;
    int idle_set[4] = '{0, 74, 0, 22};
    int stall_set[4] = '{0, 0, 74, 22};

    initial begin
        dir_rows = '{
            '{MODE_ADD, WMAX, 32'sd1, 1, '{WMIN, 0, 0, 1, 0, 0}},
            '{MODE_SUB, WMIN, 32'sd1, 1, '{WMAX, 1, 0, 0, 0, 0}},
            '{MODE_INC, WMAX, 32'sd0, 1, '{WMIN, 0, 0, 1, 0, 0}},
            '{MODE_DEC, WMIN, 32'sd0, 1, '{WMAX, 1, 0, 0, 0, 0}},
            '{MODE_DIV, 32'sd5, 32'sd0, 1, '{WMAX, 0, 0, 1, 1, 1}},
            '{MODE_DIV, 32'sd0, 32'sd0, 1, '{WMAX, 0, 1, 0, 1, 1}},
            '{MODE_DIV, -32'sd5, 32'sd0, 1, '{WMIN, 1, 0, 0, 1, 1}},
            '{MODE_MUL, WMAX, WMAX, 1, '{WMAX, 0, 1, 0, 1, 0}},
            '{MODE_MUL, WMIN, WMAX, 1, '{WMIN, 1, 0, 0, 1, 0}},
            '{MODE_MUL, 32'sd256, 32'sd256, 1, '{32'sd256, 0, 1, 0, 0, 0}},
            '{MODE_MIN, 32'sd7, 32'sd7, 1, '{32'sd7, 0, 1, 0, 0, 0}},
            '{MODE_MAX, WMIN, WMAX, 1, '{WMAX, 1, 0, 0, 0, 0}},
            '{MODE_MIN, WMIN, WMAX, 1, '{WMIN, 1, 0, 0, 0, 0}},
            '{MODE_MUL, 32'sd1, 32'sd128, 0, '0},
            '{MODE_MUL, -32'sd1, 32'sd128, 0, '0},
            '{MODE_MUL, 32'sd3, 32'sd127, 0, '0},
            '{MODE_DIV, 32'sd1, 32'sd512, 0, '0},
            '{MODE_DIV, -32'sd3, 32'sd512, 0, '0},
            '{MODE_DIV, WMIN, -32'sd1, 0, '0},
            '{MODE_DIV, WMAX, 32'sd256, 0, '0},
            '{MODE_DIV, WMIN, WMIN, 0, '0},
            '{MODE_DIV, 32'sd1, WMAX, 0, '0},
            '{MODE_MUL, WMIN, -32'sd256, 0, '0},
            '{MODE_SUB, 32'sd0, WMIN, 0, '0}
        };
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_item(row.mode, row.a, row.b);
            if (row.known && pending[$] !== row.res) begin
                table_errors++;
                $display("table row %0d: predictor gives %p, table %p", i,
                         pending[$], row.res);
            end
        end
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = idle_set[ph];
            recv_stall = stall_set[ph];
            repeat (450) send_item(mode_t'($urandom_range(0, 7)), rand_operand(),
                                   rand_operand());
        end
        s_valid <= 1'b0;
        recv_stall = 0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0 && table_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> filelist.f
rtl/fxalu_pkg.sv
rtl/fxalu_div_step.sv
rtl/fixed_point_q24_8_alu.sv
tb/fixed_point_q24_8_alu_tb.sv
